@@ sv/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Holds request and status codes and the per-cell control struct; no dependencies.
package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 8;

  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Broadcast to every cell of one chain. At most one flag is set.
  typedef struct packed {
    logic shift_up;    // take the value of the lower neighbor
    logic shift_down;  // take the value of the upper neighbor
    logic load;        // the cell whose index equals the count takes the value
  } cell_ctrl_t;

endpackage

@@ sv/deq_cell.sv @@
// One storage cell of a deque chain.
// Depends on deq_pkg for the control struct.
module deq_cell #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                   clk,
  input  deq_pkg::cell_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]       count,
  input  logic [DATA_WIDTH-1:0]  push_value,
  input  logic [DATA_WIDTH-1:0]  lower_in,
  input  logic [DATA_WIDTH-1:0]  upper_in,
  output logic [DATA_WIDTH-1:0]  value
);
  import deq_pkg::*;

  logic at_count;

  assign at_count = (count == CNT_W'(IDX));

  always_ff @(posedge clk) begin
    priority if (ctrl.shift_up) begin
      value <= lower_in;
    end else if (ctrl.shift_down) begin
      value <= upper_in;
    end else if (ctrl.load && at_count) begin
      value <= push_value;
    end else begin
      // hold
      value <= value;
    end
  end

endmodule

@@ sv/deq_chain.sv @@
// Row of deq_cell instances; cell 0 holds the element at the chain's head.
// Depends on deq_pkg and deq_cell.
module deq_chain #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = 5
) (
  input  logic                   clk,
  input  deq_pkg::cell_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]       count,
  input  logic [DATA_WIDTH-1:0]  push_value,
  output logic [DATA_WIDTH-1:0]  head
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] vals [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;

    // Head cell takes the pushed value on a shift up; last cell holds on a shift down.
    if (i == 0) begin : g_lo
      assign lower = push_value;
    end else begin : g_lo
      assign lower = vals[i-1];
    end
    if (i == DEPTH-1) begin : g_hi
      assign upper = vals[i];
    end else begin : g_hi
      assign upper = vals[i+1];
    end

    deq_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .push_value(push_value),
      .lower_in  (lower),
      .upper_in  (upper),
      .value     (vals[i])
    );
  end

  assign head = vals[0];

endmodule

@@ sv/double_ended_queue.sv @@
// Bounded double-ended queue built from two chains of shifting cells.
// Depends on deq_pkg and deq_chain.
//
// Usage: a request (req_type, push_value) enters on in_valid/in_ready. Every
// request yields one result on out_valid/out_ready: front_value, back_value
// and element_count after the request, plus status (ok, pop on empty, push
// on full). A refused request leaves the contents unchanged.
// The front chain keeps elements in order from the front, the back chain in
// order from the back, so both ends sit in cell 0 of a chain. A push
// shifts one chain by a cell and the other chain writes the cell at the
// current count; a pop shifts only the chain of its end by a cell.
// Result: registered; it is valid in the cycle after the request is taken.
// Throughput: one request per cycle while the receiver takes each result;
// the result register frees as the receiver takes it.
// Stall: while a result waits, in_ready is low and the contents hold.
// Reset: count and handshake state clear; cell contents are not cleared,
// and an empty queue reads 0 at both ends.
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             req_type,
  input  logic [DATA_WIDTH-1:0]  push_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DATA_WIDTH-1:0]  front_value,
  output logic [DATA_WIDTH-1:0]  back_value,
  output logic [CNT_W-1:0]       element_count,
  output logic [1:0]             status
);
  import deq_pkg::*;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  status_t               status_reg;
  status_t               status_next;
  cell_ctrl_t            front_ctrl;
  cell_ctrl_t            back_ctrl;
  logic [DATA_WIDTH-1:0] front_head;
  logic [DATA_WIDTH-1:0] back_head;
  logic                  fire;
  logic                  full;
  logic                  empty;
  req_t                  req;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign req      = req_t'(req_type);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    front_ctrl  = '0;
    back_ctrl   = '0;
    count_next  = count;
    status_next = ST_OK;
    if (fire) begin
      unique case (req)
        REQ_PUSH_BACK: begin
          if (full) begin
            status_next = ST_OVERFLOW;
          end else begin
            front_ctrl.load    = 1'b1;
            back_ctrl.shift_up = 1'b1;
            count_next         = count + 1'b1;
          end
        end
        REQ_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_OVERFLOW;
          end else begin
            front_ctrl.shift_up = 1'b1;
            back_ctrl.load      = 1'b1;
            count_next          = count + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            status_next = ST_UNDERFLOW;
          end else begin
            front_ctrl.shift_down = 1'b1;
            count_next            = count - 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            status_next = ST_UNDERFLOW;
          end else begin
            back_ctrl.shift_down = 1'b1;
            count_next           = count - 1'b1;
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status is payload: hold it with the result.
  always_ff @(posedge clk) begin
    if (fire) begin
      status_reg <= status_next;
    end
  end

  deq_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .CNT_W     (CNT_W)
  ) u_front_chain (
    .clk       (clk),
    .ctrl      (front_ctrl),
    .count     (count),
    .push_value(push_value),
    .head      (front_head)
  );

  deq_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .CNT_W     (CNT_W)
  ) u_back_chain (
    .clk       (clk),
    .ctrl      (back_ctrl),
    .count     (count),
    .push_value(push_value),
    .head      (back_head)
  );

  assign front_value   = empty ? '0 : front_head;
  assign back_value    = empty ? '0 : back_head;
  assign element_count = count;
  assign status        = status_reg;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count exceeds depth");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted request produced no result");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    fire && (status_next == ST_OVERFLOW) |=> count == CNT_W'(DEPTH))
    else $error("overflow reported on a queue that is not full");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    fire && !full && (req == REQ_PUSH_BACK || req == REQ_PUSH_FRONT)
      |=> count == $past(count) + 1'b1)
    else $error("accepted push did not grow the count");
`endif

endmodule

@@ tb/deq_checker.sv @@
// Scoreboard for the double-ended queue: watches the request and result channels,
// predicts each result and compares it with what the block returns.
// Depends on deq_pkg for the request and status codes.
module deq_checker #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            req_type,
  input  logic [DATA_WIDTH-1:0] push_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DATA_WIDTH-1:0] front_value,
  input  logic [DATA_WIDTH-1:0] back_value,
  input  logic [CNT_W-1:0]      element_count,
  input  logic [1:0]            status,
  output int                    error_count,
  output int                    pending
);
  import deq_pkg::*;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] back;
    logic [CNT_W-1:0]      count;
    status_t               stat;
  } deq_result_t;

  logic [DATA_WIDTH-1:0] slots [DEPTH];
  int                    head;  // slot of the front element
  int                    tail;  // slot one past the back element
  int                    held;
  deq_result_t           expected_results [$];
  deq_result_t           want;

  function automatic int next_slot(int idx);
    return (idx == DEPTH - 1) ? 0 : idx + 1;
  endfunction

  function automatic int prev_slot(int idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  // Apply one request to the shadow deque and return the result it gives.
  function automatic deq_result_t apply_request(req_t req, logic [DATA_WIDTH-1:0] value);
    deq_result_t res;
    res.stat = ST_OK;
    case (req)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (held == DEPTH) begin
          res.stat = ST_OVERFLOW;
        end else if (req == REQ_PUSH_BACK) begin
          slots[tail] = value;
          tail = next_slot(tail);
          held++;
        end else begin
          head = prev_slot(head);
          slots[head] = value;
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          res.stat = ST_UNDERFLOW;
        end else if (req == REQ_POP_FRONT) begin
          head = next_slot(head);
          held--;
        end else begin
          tail = prev_slot(tail);
          held--;
        end
      end
    endcase
    if (held == 0) begin
      res.front = '0;
      res.back  = '0;
    end else begin
      res.front = slots[head];
      res.back  = slots[prev_slot(tail)];
    end
    res.count = CNT_W'(held);
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head = 0;
      tail = 0;
      held = 0;
      error_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(),
                                apply_request(req_t'(req_type), push_value));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("front_value", want.front, front_value);
          check_field("back_value", want.back, back_value);
          check_field("element_count", want.count, element_count);
          check_field("status", want.stat, status);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the double-ended queue testbench: clock, reset, request stimulus
// and result back-pressure; checking is done by deq_checker.
// Depends on deq_pkg, double_ended_queue and deq_checker.
module tb_top;
  import deq_pkg::*;

  localparam int CNT_W      = $clog2(DEPTH_DEF + 1);
  localparam int PHASE_REQS = 256;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                req_type;
  logic [DATA_WIDTH_DEF-1:0] push_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [DATA_WIDTH_DEF-1:0] front_value;
  logic [DATA_WIDTH_DEF-1:0] back_value;
  logic [CNT_W-1:0]          element_count;
  logic [1:0]                status;
  int                        error_count;
  int                        pending;
  int                        idle_pct;
  int                        stall_pct;

  double_ended_queue i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .front_value  (front_value),
    .back_value   (back_value),
    .element_count(element_count),
    .status       (status)
  );

  deq_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .front_value  (front_value),
    .back_value   (back_value),
    .element_count(element_count),
    .status       (status),
    .error_count  (error_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

  // Offer one request, idling first at the current sender rate.
  task automatic send_req(req_t req, logic [DATA_WIDTH_DEF-1:0] value);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    push_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Result side: random stalls plus long hold-offs that back the block up.
  initial begin : receiver
    int hold_left;
    int cycle_no;
    out_ready = 1'b0;
    hold_left = 0;
    cycle_no  = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        cycle_no++;
        if (hold_left == 0 && (cycle_no == 150 || $urandom_range(0, 999) == 0)) begin
          hold_left = $urandom_range(40, 90);
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
      end
    end
  end

  initial begin : stimulus
    int push_pct;
    int burst_len;
    int sent;
    req_t req;
    in_valid   = 1'b0;
    req_type   = REQ_PUSH_BACK;
    push_value = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    rst        = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Underflow on both ends, single-element round trips, then fill to
    // full from both ends and try to push past it.
    send_req(REQ_POP_FRONT, 8'h5A);
    send_req(REQ_POP_BACK, 8'hA5);
    send_req(REQ_PUSH_BACK, 8'h00);
    send_req(REQ_POP_FRONT, 8'h00);
    send_req(REQ_PUSH_FRONT, 8'hFF);
    send_req(REQ_POP_BACK, 8'h00);
    for (int i = 0; i < DEPTH_DEF; i++) begin
      case (i)
        0:       send_req(REQ_PUSH_FRONT, 8'hFF);
        1:       send_req(REQ_PUSH_BACK, 8'h00);
        2:       send_req(REQ_PUSH_FRONT, 8'h55);
        3:       send_req(REQ_PUSH_BACK, 8'hAA);
        default: send_req(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, 8'(i * 17));
      endcase
    end
    send_req(REQ_PUSH_BACK, 8'h81);
    send_req(REQ_PUSH_FRONT, 8'h7E);
    send_req(REQ_POP_FRONT, 8'h00);
    send_req(REQ_POP_BACK, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 74; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      sent = 0;
      // Bursts lean toward pushing or popping so both full and empty are hit.
      while (sent < PHASE_REQS) begin
        burst_len = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
        for (int k = 0; k < burst_len && sent < PHASE_REQS; k++) begin
          if ($urandom_range(0, 99) < push_pct) begin
            req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
          end else begin
            req = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
          end
          send_req(req, 8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/deq_pkg.sv
sv/deq_cell.sv
sv/deq_chain.sv
sv/double_ended_queue.sv
tb/deq_checker.sv
tb/tb_top.sv
